@@ sv/vdn_pkg.sv @@
// Shared constants for the vector distance and normalize pipeline.
package vdn_pkg;

   localparam int UNIT_WIDTH = 16;
   localparam int UNIT_FRAC = 14;
   localparam int DIV_STEPS = UNIT_FRAC + 1;
   localparam int LANES = 3;

endpackage

@@ sv/vdn_sqrt_cell.sv @@
// One digit step of the pipelined square root: two radicand bits per cell.
module vdn_sqrt_cell import vdn_pkg::*; #(
   parameter int RW = 17
) (
   input  logic              clock,
   input  logic              enable,
   input  logic [RW+1:0]     rem_i,
   input  logic [RW-1:0]     root_i,
   input  logic [2*RW-1:0]   rad_i,
   output logic [RW+1:0]     rem_o,
   output logic [RW-1:0]     root_o,
   output logic [2*RW-1:0]   rad_o
);

   logic [RW+3:0]   shifted;
   logic [RW+3:0]   trial;
   logic            take;
   logic [RW+3:0]   diff;
   logic [RW+1:0]   rem_in;
   logic [RW-1:0]   root_in;
   logic [2*RW-1:0] rad_in;
   logic [RW+1:0]   rem_ff;
   logic [RW-1:0]   root_ff;
   logic [2*RW-1:0] rad_ff;

   always_comb begin
      shifted = {rem_i, rad_i[2*RW-1:2*RW-2]};
      trial = {2'b00, root_i, 2'b01};
      take = (shifted >= trial);
      diff = shifted - trial;
      rem_in = take ? diff[RW+1:0] : shifted[RW+1:0];
      root_in = {root_i[RW-2:0], take};
      rad_in = {rad_i[2*RW-3:0], 2'b00};
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rem_ff <= rem_in;
         root_ff <= root_in;
         rad_ff <= rad_in;
      end
   end

   assign rem_o = rem_ff;
   assign root_o = root_ff;
   assign rad_o = rad_ff;

endmodule

@@ sv/vdn_div_cell.sv @@
// One quotient bit of the restoring divide, for all three components at once.
module vdn_div_cell import vdn_pkg::*; #(
   parameter int RW = 17,
   parameter bit FIRST = 1'b0
) (
   input  logic                            clock,
   input  logic                            enable,
   input  logic [RW-1:0]                   den_i,
   input  logic [LANES-1:0][RW:0]          rem_i,
   input  logic [LANES-1:0][DIV_STEPS-1:0] quo_i,
   output logic [RW-1:0]                   den_o,
   output logic [LANES-1:0][RW:0]          rem_o,
   output logic [LANES-1:0][DIV_STEPS-1:0] quo_o
);

   logic [LANES-1:0][RW:0]          part;
   logic [LANES-1:0]                ge;
   logic [LANES-1:0][RW:0]          rem_in;
   logic [LANES-1:0][DIV_STEPS-1:0] quo_in;
   logic [RW-1:0]                   den_ff;
   logic [LANES-1:0][RW:0]          rem_ff;
   logic [LANES-1:0][DIV_STEPS-1:0] quo_ff;

   always_comb begin
      for (int k = 0; k < LANES; k++) begin
         part[k] = FIRST ? rem_i[k] : {rem_i[k][RW-1:0], 1'b0};
         ge[k] = (part[k] >= {1'b0, den_i});
         rem_in[k] = ge[k] ? part[k] - {1'b0, den_i} : part[k];
         quo_in[k] = {quo_i[k][DIV_STEPS-2:0], ge[k]};
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         den_ff <= den_i;
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign den_o = den_ff;
   assign rem_o = rem_ff;
   assign quo_o = quo_ff;

endmodule

@@ sv/vector_distance_normalize.sv @@
// Top level: displacement, Euclidean length and unit direction of two points.
// The displacement, squares and sum are registered in turn, then come one cell per root bit,
// fifteen divide cells and one output register.
// Throughput is one transfer per cycle; each pipeline stage moves on when the next has room.
// Reset clears all valid flags; data registers hold whatever they last captured.
module vector_distance_normalize import vdn_pkg::*; #(
   parameter int COORD_WIDTH = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // head_x, head_y, head_z, tail_x, tail_y, tail_z from the lowest bit up.
   input  logic [((6*COORD_WIDTH+7)/8)*8-1:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // length, unit_x, unit_y, unit_z from the lowest bit up.
   output logic [((COORD_WIDTH+1+3*UNIT_WIDTH+7)/8)*8-1:0] rsp_tdata,
   // zero_length.
   output logic rsp_tuser
);

   localparam int CW = COORD_WIDTH;
   localparam int RW = CW + 1;
   localparam int SW = 2 * RW;
   localparam int OUT_W = ((RW + 3*UNIT_WIDTH + 7) / 8) * 8;
   localparam int SQ0 = 3;
   localparam int DV0 = SQ0 + RW;
   localparam int OS = DV0 + DIV_STEPS;
   localparam int S = OS + 1;

   logic [S-1:0] v_ff;
   logic [S-1:0] v_in;
   logic [S-1:0] adv;

   logic [LANES-1:0][CW-1:0] ab_ff [DV0];
   logic [LANES-1:0]         sg_ff [OS];
   logic [LANES-1:0][2*CW-1:0] sq_ff;
   logic [SW-1:0]            sum_ff;

   logic [RW+1:0]   sq_rem [RW+1];
   logic [RW-1:0]   sq_root [RW+1];
   logic [SW-1:0]   sq_rad [RW+1];

   logic [RW-1:0]                   dv_den [DIV_STEPS+1];
   logic [LANES-1:0][RW:0]          dv_rem [DIV_STEPS+1];
   logic [LANES-1:0][DIV_STEPS-1:0] dv_quo [DIV_STEPS+1];

   logic [LANES-1:0][CW:0]   diff;
   logic [LANES-1:0][CW-1:0] mag;
   logic [LANES-1:0]         neg;
   logic [LANES-1:0][UNIT_WIDTH-1:0] unit_in;
   logic                     zero_in;
   logic [RW-1:0]            len_ff;
   logic [LANES-1:0][UNIT_WIDTH-1:0] unit_ff;
   logic                     zero_ff;

   function automatic logic [2*CW-1:0] mag_sq(input logic [CW-1:0] a);
      mag_sq = a * a;
   endfunction

   always_comb begin
      adv[S-1] = !v_ff[S-1] || rsp_tready;
      for (int i = S - 2; i >= 0; i--) begin
         adv[i] = !v_ff[i] || adv[i+1];
      end
      v_in[0] = req_tvalid;
      for (int i = 1; i < S; i++) begin
         v_in[i] = v_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int i = 0; i < S; i++) begin
            if (adv[i]) begin
               v_ff[i] <= v_in[i];
            end
         end
      end
   end

   assign req_tready = adv[0];

   always_comb begin
      for (int k = 0; k < LANES; k++) begin
         diff[k] = {req_tdata[k*CW+CW-1], req_tdata[k*CW +: CW]}
                 - {req_tdata[(k+3)*CW+CW-1], req_tdata[(k+3)*CW +: CW]};
         neg[k] = diff[k][CW];
         mag[k] = neg[k] ? CW'(-diff[k]) : diff[k][CW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         ab_ff[0] <= mag;
         sg_ff[0] <= neg;
      end
      if (adv[1]) begin
         for (int k = 0; k < LANES; k++) begin
            sq_ff[k] <= mag_sq(ab_ff[0][k]);
         end
      end
      if (adv[2]) begin
         sum_ff <= SW'(sq_ff[0]) + SW'(sq_ff[1]) + SW'(sq_ff[2]);
      end
      for (int i = 1; i < DV0; i++) begin
         if (adv[i]) begin
            ab_ff[i] <= ab_ff[i-1];
         end
      end
      for (int i = 1; i < OS; i++) begin
         if (adv[i]) begin
            sg_ff[i] <= sg_ff[i-1];
         end
      end
   end

   assign sq_rem[0] = '0;
   assign sq_root[0] = '0;
   assign sq_rad[0] = sum_ff;

   for (genvar k = 0; k < RW; k++) begin : g_sqrt
      vdn_sqrt_cell #(.RW(RW)) u_cell (
         .clock  (clock),
         .enable (adv[SQ0+k]),
         .rem_i  (sq_rem[k]),
         .root_i (sq_root[k]),
         .rad_i  (sq_rad[k]),
         .rem_o  (sq_rem[k+1]),
         .root_o (sq_root[k+1]),
         .rad_o  (sq_rad[k+1])
      );
   end

   assign dv_den[0] = sq_root[RW];
   assign dv_quo[0] = '0;
   for (genvar k = 0; k < LANES; k++) begin : g_dv_in
      assign dv_rem[0][k] = {2'b00, ab_ff[DV0-1][k]};
   end

   for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
      vdn_div_cell #(.RW(RW), .FIRST(j == 0)) u_cell (
         .clock  (clock),
         .enable (adv[DV0+j]),
         .den_i  (dv_den[j]),
         .rem_i  (dv_rem[j]),
         .quo_i  (dv_quo[j]),
         .den_o  (dv_den[j+1]),
         .rem_o  (dv_rem[j+1]),
         .quo_o  (dv_quo[j+1])
      );
   end

   always_comb begin
      zero_in = (dv_den[DIV_STEPS] == '0);
      for (int k = 0; k < LANES; k++) begin
         if (zero_in) begin
            unit_in[k] = '0;
         end else if (sg_ff[OS-1][k]) begin
            unit_in[k] = UNIT_WIDTH'(-{1'b0, dv_quo[DIV_STEPS][k]});
         end else begin
            unit_in[k] = {1'b0, dv_quo[DIV_STEPS][k]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv[OS]) begin
         len_ff <= dv_den[DIV_STEPS];
         unit_ff <= unit_in;
         zero_ff <= zero_in;
      end
   end

   assign rsp_tvalid = v_ff[S-1];
   assign rsp_tdata = OUT_W'({unit_ff[2], unit_ff[1], unit_ff[0], len_ff});
   assign rsp_tuser = zero_ff;

   a_zero_units: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> len_ff == '0 && unit_ff == '0)
      else $error("zero length result carries nonzero fields");

   a_nonzero_len: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> len_ff != '0)
      else $error("nonzero result carries zero length");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled while output stage is empty");

endmodule
